@@ rtl/dtp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the duration text parser.
// No dependencies; imported by every module of the block.
package dtp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Unit of one component, as decoded by the front end
  typedef logic [3:0] unit_kind_t;
  localparam unit_kind_t UK_NONE = 4'd0;
  localparam unit_kind_t UK_YEAR = 4'd1;
  localparam unit_kind_t UK_WEEK = 4'd2;
  localparam unit_kind_t UK_DAY  = 4'd3;
  localparam unit_kind_t UK_HOUR = 4'd4;
  localparam unit_kind_t UK_MIN  = 4'd5;
  localparam unit_kind_t UK_SEC  = 4'd6;
  localparam unit_kind_t UK_MS   = 4'd7;
  localparam unit_kind_t UK_US   = 4'd8;
  localparam unit_kind_t UK_NS   = 4'd9;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_UNIT  = 2'd1;
  localparam status_t ST_BAD_UNIT = 2'd2;

  // One work command from the front end to the arithmetic back end
  typedef struct packed {
    logic       do_eval;
    unit_kind_t kind;
    logic [31:0] whole;
    logic [31:0] frac;
    logic       sign_seen;
    logic       sign_minus;
    logic       last;
    status_t    err;
  } dtp_cmd_t;

endpackage

@@ rtl/dtp_front.sv @@
`timescale 1ns / 1ps
// Front end: walks the text one byte per item, tracks the parse phase and
// emits work commands (unit evaluation, sign, end of text). Uses dtp_pkg.
module dtp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              text_valid,
  input  logic [7:0]        text_byte,
  input  logic              text_last,
  output logic              cmd_push,
  output dtp_pkg::dtp_cmd_t cmd
);
  import dtp_pkg::*;

  localparam logic [2:0] PH_SKIP1 = 3'd0;
  localparam logic [2:0] PH_NUM   = 3'd1;
  localparam logic [2:0] PH_FRAC  = 3'd2;
  localparam logic [2:0] PH_SKIP2 = 3'd3;
  localparam logic [2:0] PH_UNIT  = 3'd4;
  localparam logic [2:0] PH_COMMA = 3'd5;

  localparam logic [7:0] CH_Y     = 8'h79;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_MU_HI = 8'hC2;
  localparam logic [7:0] CH_MU_LO = 8'hB5;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    unit_kind_t kind;
    status_t    err;
  } unit_dec_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_unit_byte(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_MU_HI) || (c == CH_MU_LO);
  endfunction

  // Judge a unit word by its first three bytes and its saturated length
  function automatic unit_dec_t unit_decode(input logic [7:0] c1, input logic [7:0] c2,
                                            input logic [7:0] c3, input logic [1:0] len);
    unit_dec_t d;
    d.kind = UK_NONE;
    d.err  = ST_OK;
    if (len == 2'd0) begin
      d.err = ST_NO_UNIT;
    end else begin
      unique case (c1)
        CH_Y: d.kind = UK_YEAR;
        CH_W: d.kind = UK_WEEK;
        CH_D: d.kind = UK_DAY;
        CH_H: d.kind = UK_HOUR;
        CH_S: d.kind = UK_SEC;
        CH_N: d.kind = UK_NS;
        CH_U: d.kind = UK_US;
        CH_M: begin
          if ((len == 2'd1) || ((c2 == CH_I) && (len == 2'd2)) ||
              ((c2 == CH_I) && (c3 == CH_N))) begin
            d.kind = UK_MIN;
          end else if ((c2 == CH_S) || ((c2 == CH_I) && (c3 == CH_L))) begin
            d.kind = UK_MS;
          end else if ((c2 == CH_I) && (c3 == CH_C)) begin
            d.kind = UK_US;
          end else if (c2 != CH_I) begin
            d.err = ST_BAD_UNIT;
          end
          // any other "mi" word adds nothing and is no error
        end
        CH_MU_HI: begin
          if ((len != 2'd1) && (c2 == CH_MU_LO)) begin
            d.kind = UK_US;
          end else begin
            d.err = ST_BAD_UNIT;
          end
        end
        default: d.err = ST_BAD_UNIT;
      endcase
    end
    return d;
  endfunction

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] whole_r, whole_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic [1:0]  fdig_r, fdig_nxt;
  logic [7:0]  uc1_r, uc1_nxt;
  logic [7:0]  uc2_r, uc2_nxt;
  logic [7:0]  uc3_r, uc3_nxt;
  logic [1:0]  ulen_r, ulen_nxt;
  status_t     err_r, err_nxt;

  unit_dec_t dec_pre;
  unit_dec_t dec_post;
  logic      ev_pre;
  logic      ev_post;
  logic      sign_seen;
  logic      sign_minus;
  logic      go_skip1;
  logic      go_num;
  logic      go_skip2;

  assign dec_pre = unit_decode(uc1_r, uc2_r, uc3_r, ulen_r);

  always_comb begin
    phase_nxt  = phase_r;
    whole_nxt  = whole_r;
    frac_nxt   = frac_r;
    fdig_nxt   = fdig_r;
    uc1_nxt    = uc1_r;
    uc2_nxt    = uc2_r;
    uc3_nxt    = uc3_r;
    ulen_nxt   = ulen_r;
    err_nxt    = err_r;
    ev_pre     = 1'b0;
    ev_post    = 1'b0;
    sign_seen  = 1'b0;
    sign_minus = 1'b0;
    go_skip1   = 1'b0;
    go_num     = 1'b0;
    go_skip2   = 1'b0;

    if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_UNIT: begin
          if (is_unit_byte(text_byte)) begin
            case (ulen_r)
              2'd0:    uc1_nxt = text_byte;
              2'd1:    uc2_nxt = text_byte;
              2'd2:    uc3_nxt = text_byte;
              default: uc3_nxt = uc3_r;
            endcase
            if (ulen_r != 2'd3) ulen_nxt = ulen_r + 2'd1;
          end else if (dec_pre.err != ST_OK) begin
            err_nxt = dec_pre.err;
          end else begin
            // unit ends here: hand it over, then reparse this byte
            ev_pre    = 1'b1;
            whole_nxt = '0;
            frac_nxt  = '0;
            phase_nxt = PH_SKIP1;
            go_skip1  = (text_byte != CH_COMMA);
          end
        end
        PH_COMMA: begin
          phase_nxt = PH_SKIP1;
          go_skip1  = (text_byte != CH_COMMA);
        end
        PH_NUM: go_num = 1'b1;
        PH_FRAC: begin
          if (is_digit(text_byte)) begin
            if (fdig_r != 2'd3) fdig_nxt = fdig_r + 2'd1;
            frac_nxt = frac_r * 32'd10 + {28'd0, text_byte[3:0]};
          end else begin
            case (fdig_r)
              2'd0:    frac_nxt = frac_r * 32'd1000;
              2'd1:    frac_nxt = frac_r * 32'd100;
              2'd2:    frac_nxt = frac_r * 32'd10;
              default: frac_nxt = frac_r;
            endcase
            fdig_nxt = 2'd0;
            go_skip2 = 1'b1;
          end
        end
        PH_SKIP2: go_skip2 = 1'b1;
        default: begin
          phase_nxt = PH_SKIP1;
          go_skip1  = 1'b1;
        end
      endcase

      if (go_skip1 && !is_space(text_byte)) begin
        phase_nxt = PH_NUM;
        if (text_byte == CH_MINUS) begin
          sign_seen  = 1'b1;
          sign_minus = 1'b1;
        end else if (text_byte == CH_PLUS) begin
          sign_seen = 1'b1;
        end else begin
          go_num = 1'b1;
        end
      end

      if (go_num) begin
        if (is_digit(text_byte)) begin
          whole_nxt = whole_nxt * 32'd10 + {28'd0, text_byte[3:0]};
        end else if (text_byte == CH_DOT) begin
          phase_nxt = PH_FRAC;
          fdig_nxt  = 2'd0;
        end else begin
          go_skip2 = 1'b1;
        end
      end

      if (go_skip2) begin
        phase_nxt = PH_SKIP2;
        if (!is_space(text_byte)) begin
          phase_nxt = PH_UNIT;
          if (is_unit_byte(text_byte)) begin
            uc1_nxt  = text_byte;
            ulen_nxt = 2'd1;
          end else begin
            ulen_nxt = 2'd0;
            err_nxt  = ST_NO_UNIT;
          end
        end
      end
    end

    // a unit still open at the end of the text is evaluated now
    dec_post = unit_decode(uc1_nxt, uc2_nxt, uc3_nxt, ulen_nxt);
    if (text_last && (err_nxt == ST_OK) && (phase_nxt == PH_UNIT)) begin
      if (dec_post.err != ST_OK) begin
        err_nxt = dec_post.err;
      end else begin
        ev_post = 1'b1;
      end
    end

    cmd.do_eval    = ev_pre || ev_post;
    cmd.kind       = ev_pre ? dec_pre.kind : dec_post.kind;
    cmd.whole      = ev_pre ? whole_r : whole_nxt;
    cmd.frac       = ev_pre ? frac_r : frac_nxt;
    cmd.sign_seen  = sign_seen;
    cmd.sign_minus = sign_minus;
    cmd.last       = text_last;
    cmd.err        = err_nxt;
    cmd_push       = text_valid && (ev_pre || ev_post || sign_seen || text_last);

    if (text_last) begin
      phase_nxt = PH_SKIP1;
      whole_nxt = '0;
      frac_nxt  = '0;
      fdig_nxt  = 2'd0;
      uc1_nxt   = '0;
      uc2_nxt   = '0;
      uc3_nxt   = '0;
      ulen_nxt  = 2'd0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP1;
      whole_r <= '0;
      frac_r  <= '0;
      fdig_r  <= 2'd0;
      uc1_r   <= '0;
      uc2_r   <= '0;
      uc3_r   <= '0;
      ulen_r  <= 2'd0;
      err_r   <= ST_OK;
    end else if (text_valid) begin
      phase_r <= phase_nxt;
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
      fdig_r  <= fdig_nxt;
      uc1_r   <= uc1_nxt;
      uc2_r   <= uc2_nxt;
      uc3_r   <= uc3_nxt;
      ulen_r  <= ulen_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ rtl/dtp_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between the parsing front end and the arithmetic
// back end. Uses dtp_pkg for the command type.
module dtp_queue #(
  parameter int unsigned DEPTH = dtp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dtp_pkg::dtp_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output dtp_pkg::dtp_cmd_t head
);
  import dtp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dtp_cmd_t       mem [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/dtp_back.sv @@
`timescale 1ns / 1ps
// Back end: scales each component to nanoseconds in a short multiply
// pipeline, accumulates the total and drives the result register. Uses dtp_pkg.
module dtp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  dtp_pkg::dtp_cmd_t q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic [1:0]        out_tuser
);
  import dtp_pkg::*;

  localparam int unsigned CB_W = 46;

  typedef struct packed {
    logic    sign_seen;
    logic    sign_minus;
    logic    last;
    status_t err;
  } dtp_tag_t;

  // multiplier applied to the whole part before the 32-bit wrap
  function automatic logic [8:0] ma_of(input unit_kind_t k);
    unique case (k)
      UK_YEAR: return 9'd365;
      UK_WEEK: return 9'd7;
      default: return 9'd1;
    endcase
  endfunction

  // nanoseconds per unit of the (wrapped) whole part
  function automatic logic [63:0] ka_of(input unit_kind_t k);
    unique case (k)
      UK_YEAR, UK_WEEK, UK_DAY: return 64'd86400000000000;
      UK_HOUR: return 64'd3600000000000;
      UK_MIN:  return 64'd60000000000;
      UK_SEC:  return 64'd1000000000;
      UK_MS:   return 64'd1000000;
      UK_US:   return 64'd1000;
      UK_NS:   return 64'd1;
      default: return 64'd0;
    endcase
  endfunction

  // nanoseconds per thousandth of the unit
  function automatic logic [CB_W-1:0] cb_of(input unit_kind_t k);
    unique case (k)
      UK_YEAR: return 46'd31536000000000;
      UK_WEEK: return 46'd604800000000;
      UK_DAY:  return 46'd86400000000;
      UK_HOUR: return 46'd3600000000;
      UK_MIN:  return 46'd60000000;
      UK_SEC:  return 46'd1000000;
      UK_MS:   return 46'd1000;
      UK_US:   return 46'd1;
      default: return 46'd0;
    endcase
  endfunction

  logic en;

  // stage 1: fraction overflow and whole-part prescale
  logic            s1_valid_r;
  dtp_tag_t        s1_tag_r;
  unit_kind_t      s1_kind_r;
  logic [31:0]     s1_a_r;
  logic [9:0]      s1_f_r;
  unit_kind_t      h_kind;
  logic            h_over;
  logic [31:0]     h_whole;
  logic [40:0]     h_a_full;

  // stage 2: partial products
  logic            s2_valid_r;
  dtp_tag_t        s2_tag_r;
  logic [63:0]     s2_pa_lo_r;
  logic [31:0]     s2_pa_hi_r;
  logic [55:0]     s2_pb_r;
  logic [63:0]     s1_ka;
  logic [63:0]     pa_lo;
  logic [31:0]     pa_hi;
  logic [55:0]     pb;

  // stage 3: component sum
  logic            s3_valid_r;
  dtp_tag_t        s3_tag_r;
  logic [63:0]     s3_add_r;

  // stage 4: accumulate, sign check, end of text
  logic [63:0]     total_r, total_nxt;
  logic            neg_r, neg_nxt;
  logic            berr_r, berr_nxt;
  logic [63:0]     tot_step;
  logic            neg_step;
  logic            berr_step;
  logic            fin_valid_r;
  logic [63:0]     fin_total_r;
  logic            fin_neg_r;
  status_t         fin_status_r;
  status_t         fin_status_nxt;

  // stage 5: result register
  logic            out_valid_r;
  logic [63:0]     out_total_r;
  status_t         out_status_r;

  // whole back end holds while a result waits unread
  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && !q_empty;

  assign h_kind   = q_head.do_eval ? q_head.kind : UK_NONE;
  assign h_over   = (q_head.frac > 32'd999);
  assign h_whole  = q_head.whole + {31'd0, h_over};
  assign h_a_full = h_whole * ma_of(h_kind);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r  <= '{sign_seen:  q_head.sign_seen, sign_minus: q_head.sign_minus,
                     last:       q_head.last,      err:        q_head.err};
      s1_kind_r <= h_kind;
      s1_a_r    <= h_a_full[31:0];
      s1_f_r    <= h_over ? 10'd0 : q_head.frac[9:0];
    end
  end

  assign s1_ka = ka_of(s1_kind_r);
  assign pa_lo = s1_a_r * s1_ka[31:0];
  assign pa_hi = s1_a_r * s1_ka[63:32];
  assign pb    = s1_f_r * cb_of(s1_kind_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag_r   <= s1_tag_r;
      s2_pa_lo_r <= pa_lo;
      s2_pa_hi_r <= pa_hi;
      s2_pb_r    <= pb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag_r <= s2_tag_r;
      s3_add_r <= s2_pa_lo_r + {s2_pa_hi_r, 32'd0} + {8'd0, s2_pb_r};
    end
  end

  always_comb begin
    tot_step  = total_r;
    neg_step  = neg_r;
    berr_step = berr_r;
    if (!berr_r) begin
      tot_step = total_r + s3_add_r;
      // a sign counts only while the total is still zero
      if (s3_tag_r.sign_seen) begin
        if (tot_step == 64'd0) begin
          neg_step = neg_r | s3_tag_r.sign_minus;
        end else begin
          berr_step = 1'b1;
        end
      end
    end
    fin_status_nxt = berr_step ? ST_NO_UNIT : s3_tag_r.err;

    total_nxt = total_r;
    neg_nxt   = neg_r;
    berr_nxt  = berr_r;
    if (en && s3_valid_r) begin
      if (s3_tag_r.last) begin
        total_nxt = '0;
        neg_nxt   = 1'b0;
        berr_nxt  = 1'b0;
      end else begin
        total_nxt = tot_step;
        neg_nxt   = neg_step;
        berr_nxt  = berr_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_total_r  <= tot_step;
      fin_neg_r    <= neg_step;
      fin_status_r <= fin_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && fin_valid_r) begin
      out_status_r <= fin_status_r;
      if (fin_status_r != ST_OK) begin
        out_total_r <= '0;
      end else if (fin_neg_r) begin
        out_total_r <= 64'd0 - fin_total_r;
      end else begin
        out_total_r <= fin_total_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      neg_r       <= 1'b0;
      berr_r      <= 1'b0;
    end else begin
      total_r <= total_nxt;
      neg_r   <= neg_nxt;
      berr_r  <= berr_nxt;
      if (en) begin
        s1_valid_r  <= !q_empty;
        s2_valid_r  <= s1_valid_r;
        s3_valid_r  <= s2_valid_r;
        fin_valid_r <= s3_valid_r && s3_tag_r.last;
        out_valid_r <= fin_valid_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_total_r;
  assign out_tuser  = out_status_r;

endmodule

@@ rtl/duration_text_parser.sv @@
`timescale 1ns / 1ps
// Duration text parser: takes duration text a byte at a time and returns the
// total in nanoseconds. Uses dtp_pkg, dtp_front, dtp_queue and dtp_back.
//
// Input channel: one text byte per item on in_tdata; in_tlast marks the last
// byte of a text. Output channel: one result per text, issued for the last
// byte, with the signed nanosecond total on out_tdata and the status on
// out_tuser (0 ok, 1 value without unit, 2 unknown unit; total 0 on error).
// A number left without a unit at the end of the text is dropped.
// Throughput: one byte per cycle while in_tready is high. The front end
// settles each byte in the cycle it is accepted; the back end, unless the
// receiver stalls it, scales one component per cycle through three pipeline
// stages with 32x32 multipliers and sums it into the total.
// A stalled receiver holds the result register and the back end; the front
// end keeps taking bytes until the command queue is full, then in_tready drops.
// Reset (rst_n low, synchronous) empties the queue and pipeline and returns the
// parser to the start of a text with a zero total.
module duration_text_parser #(
  parameter int unsigned QUEUE_DEPTH = dtp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] total_nanoseconds
  output logic [1:0]  out_tuser   // [1:0] parse_status
);
  import dtp_pkg::*;

  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  logic     cmd_push;
  logic     accept;
  dtp_cmd_t cmd;
  dtp_cmd_t q_head;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  dtp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (accept),
    .text_byte  (in_tdata),
    .text_last  (in_tlast),
    .cmd_push   (cmd_push),
    .cmd        (cmd)
  );

  dtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  dtp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
